### hw/rtl/swrv_pkg.sv
// Shared types and constants for the sliding window range variance block.
// Holds the word structs, the front-to-back command, the back state type and the scale constants.
// Depends on nothing; every other file of the block imports it.
package swrv_pkg;

    localparam int WINDOW_DEF = 50;

    localparam int RANGE_W = 16;
    localparam int KIND_W  = 8;
    localparam int COV_W   = 8;

    localparam int VAR_SCALE = 10000;
    localparam int SCALE_W   = $clog2(VAR_SCALE + 1);

    localparam logic [COV_W-1:0] COV_MAX = COV_W'(255);
    localparam int Q_BITS = COV_W + 1;

    localparam int CMD_DEPTH = 2;
    localparam int CMD_PW    = $clog2(CMD_DEPTH);
    localparam int CMD_CW    = $clog2(CMD_DEPTH + 1);

    localparam logic [KIND_W-1:0] KIND_ULTRASOUND   = KIND_W'(0);
    localparam logic              SENSOR_LASER      = 1'b0;
    localparam logic              SENSOR_ULTRASOUND = 1'b1;

    typedef struct packed {
        logic [RANGE_W-1:0] range_mm;
        logic [KIND_W-1:0]  radiation_kind;
    } t_in_word;

    typedef struct packed {
        logic [COV_W-1:0] covariance_out;
        logic             sensor_type;
        logic             clipped;
    } t_out_word;

    typedef struct packed {
        logic               use_fixed;
        logic [COV_W-1:0]   fixed_val;
        logic               sensor_type;
        logic [RANGE_W-1:0] range_mm;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_OSQ,
        ST_UPD,
        ST_MUL,
        ST_DIFF,
        ST_DIV,
        ST_DONE
    } t_back_state;

endpackage

### hw/rtl/sliding_window_range_variance.sv
// Top level of the sliding window range variance block.
// Joins the front end (swrv_front) and the back end (swrv_back); depends on swrv_pkg.
//
//   channel   direction  handshake              word
//   input     in         push / full            t_in_word
//   result    out        empty / pop            t_out_word
//   config    in         i_cfg_valid / ready    fixed covariance byte
//
// A computed word passes through the square and product stages and the 9-step
// restoring divider in the back end; a fixed-value word goes straight to the result.
// The front queue holds two words, so push is taken every cycle until it fills.
// Synchronous active-low reset clears the sums, fill count, pointers and config.
// A result waiting on pop stalls only the back end; the front keeps taking words until its queue fills.
module sliding_window_range_variance #(
    parameter int WINDOW = swrv_pkg::WINDOW_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  swrv_pkg::t_in_word         i_in_word,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [swrv_pkg::COV_W-1:0] i_cfg_data,
    output logic                       empty,
    input  logic                       pop,
    output swrv_pkg::t_out_word        o_out_word
);
    import swrv_pkg::*;

    logic w_cmd_valid;
    t_cmd w_cmd;
    logic w_cmd_take;

    swrv_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_word   (i_in_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_take  (w_cmd_take)
    );

    swrv_back #(
        .WINDOW (WINDOW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_take  (w_cmd_take),
        .pop         (pop),
        .empty       (empty),
        .o_out_word  (o_out_word)
    );

endmodule

### hw/rtl/swrv_front.sv
// Front end: accepts input words, holds the fixed covariance register and classifies each word.
// Classified commands wait in a short queue for the back end.
// Depends on swrv_pkg.
module swrv_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  swrv_pkg::t_in_word         i_in_word,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [swrv_pkg::COV_W-1:0] i_cfg_data,
    output logic                       o_cmd_valid,
    output swrv_pkg::t_cmd             o_cmd,
    input  logic                       i_cmd_take
);
    import swrv_pkg::*;

    logic [COV_W-1:0]  r_fixed, n_fixed;
    logic [CMD_PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [CMD_PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CMD_CW-1:0] r_count, n_count;
    t_cmd              r_cmd_q [CMD_DEPTH];
    t_cmd              w_cmd;
    logic              w_push_ok;
    logic              w_take;

    assign o_cfg_ready = 1'b1;
    assign full        = (r_count == CMD_CW'(CMD_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_cmd_q[r_rd_ptr];
    assign w_push_ok   = push && !full;
    assign w_take      = i_cmd_take && o_cmd_valid;

    always_comb begin
        w_cmd.use_fixed   = (r_fixed != '0);
        w_cmd.fixed_val   = r_fixed;
        w_cmd.sensor_type = (i_in_word.radiation_kind == KIND_ULTRASOUND) ?
                            SENSOR_ULTRASOUND : SENSOR_LASER;
        w_cmd.range_mm    = i_in_word.range_mm;
    end

    always_comb begin
        n_fixed  = (i_cfg_valid && o_cfg_ready) ? i_cfg_data : r_fixed;
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (w_push_ok) begin
            n_wr_ptr = (r_wr_ptr == CMD_PW'(CMD_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_take) begin
            n_rd_ptr = (r_rd_ptr == CMD_PW'(CMD_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        n_count = r_count + CMD_CW'(w_push_ok) - CMD_CW'(w_take);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fixed  <= '0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_fixed  <= n_fixed;
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_cmd_q[r_wr_ptr] <= w_cmd;
        end
    end

endmodule

### hw/rtl/swrv_back.sv
// Back end: window memory, running sums, product stages and a restoring divider.
// Takes commands from the front queue and fills the result register.
// Depends on swrv_pkg.
module swrv_back #(
    parameter int WINDOW = swrv_pkg::WINDOW_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  swrv_pkg::t_cmd      i_cmd,
    output logic                o_cmd_take,
    input  logic                pop,
    output logic                empty,
    output swrv_pkg::t_out_word o_out_word
);
    import swrv_pkg::*;

    localparam int CW  = $clog2(WINDOW + 1);
    localparam int IW  = $clog2(WINDOW);
    localparam int SW  = RANGE_W + CW;
    localparam int SQW = 2 * RANGE_W + CW;
    localparam int NW  = 2 * RANGE_W + 2 * CW;
    localparam int DW  = 2 * CW + SCALE_W;
    localparam int SCW = $clog2(Q_BITS);

    t_back_state        r_state, n_state;
    logic [CW-1:0]      r_fill, n_fill;
    logic [IW-1:0]      r_wslot, n_wslot;
    logic [SW-1:0]      r_sum, n_sum;
    logic [SQW-1:0]     r_sumsq, n_sumsq;
    logic               r_out_valid, n_out_valid;
    t_out_word          r_out_word;

    logic [RANGE_W-1:0] r_mem [WINDOW];
    logic [RANGE_W-1:0] r_rd_data;
    t_cmd               r_cmd;
    logic [2*RANGE_W-1:0] r_xsq, r_osq;
    logic [NW-1:0]      r_p1, r_p2;
    logic [2*CW-1:0]    r_nn;
    logic [NW-1:0]      r_rem, r_dsh;
    logic [Q_BITS-1:0]  r_q;
    logic [SCW-1:0]     r_step;

    logic               w_full;
    logic [RANGE_W-1:0] w_old;
    logic [IW-1:0]      w_mem_addr;
    logic               w_mem_we;
    logic               w_load_out;
    logic               w_out_free;
    logic [NW-1:0]      w_p1, w_p2;
    logic [2*CW-1:0]    w_nn;
    logic [DW-1:0]      w_den;
    logic               w_ge;
    logic               w_clip;
    t_out_word          w_result;

    assign w_full     = (r_fill == CW'(WINDOW));
    assign w_old      = w_full ? r_rd_data : '0;
    assign w_mem_addr = w_full ? r_wslot : r_fill[IW-1:0];
    assign w_out_free = !r_out_valid || pop;
    assign w_p1       = NW'(r_fill) * NW'(r_sumsq);
    assign w_p2       = NW'(r_sum) * NW'(r_sum);
    assign w_nn       = (2 * CW)'(r_fill) * (2 * CW)'(r_fill);
    assign w_den      = DW'(r_nn) * DW'(VAR_SCALE);
    assign w_ge       = (r_rem >= r_dsh);
    assign w_clip     = r_q[Q_BITS-1];

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = i_cmd.use_fixed ? ST_DONE : ST_READ;
                end
            end
            ST_READ: n_state = ST_OSQ;
            ST_OSQ:  n_state = ST_UPD;
            ST_UPD:  n_state = ST_MUL;
            ST_MUL:  n_state = ST_DIFF;
            ST_DIFF: n_state = ST_DIV;
            ST_DIV: begin
                if (r_step == SCW'(Q_BITS - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_take = 1'b0;
        w_mem_we   = 1'b0;
        w_load_out = 1'b0;
        case (r_state)
            ST_IDLE: o_cmd_take = i_cmd_valid;
            ST_UPD:  w_mem_we   = 1'b1;
            ST_DONE: w_load_out = w_out_free;
            default: ;
        endcase
    end

    always_comb begin
        n_fill      = r_fill;
        n_wslot     = r_wslot;
        n_sum       = r_sum;
        n_sumsq     = r_sumsq;
        if (w_mem_we) begin
            n_sum   = r_sum + SW'(r_cmd.range_mm) - SW'(w_old);
            n_sumsq = r_sumsq + SQW'(r_xsq) - SQW'(r_osq);
            if (w_full) begin
                n_wslot = (r_wslot == IW'(WINDOW - 1)) ? '0 : r_wslot + 1'b1;
            end else begin
                n_fill  = r_fill + 1'b1;
            end
        end
        n_out_valid = r_out_valid;
        if (w_load_out) begin
            n_out_valid = 1'b1;
        end else if (pop && r_out_valid) begin
            n_out_valid = 1'b0;
        end
    end

    always_comb begin
        w_result.sensor_type = r_cmd.sensor_type;
        if (r_cmd.use_fixed) begin
            w_result.covariance_out = r_cmd.fixed_val;
            w_result.clipped        = 1'b0;
        end else begin
            w_result.covariance_out = w_clip ? COV_MAX : r_q[COV_W-1:0];
            w_result.clipped        = w_clip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_wslot     <= '0;
            r_sum       <= '0;
            r_sumsq     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_wslot     <= n_wslot;
            r_sum       <= n_sum;
            r_sumsq     <= n_sumsq;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_addr] <= r_cmd.range_mm;
        end
        r_rd_data <= r_mem[r_wslot];
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_take) begin
            r_cmd <= i_cmd;
        end
        if (w_load_out) begin
            r_out_word <= w_result;
        end
        case (r_state)
            ST_READ: r_xsq <= (2 * RANGE_W)'(r_cmd.range_mm) * (2 * RANGE_W)'(r_cmd.range_mm);
            ST_OSQ:  r_osq <= (2 * RANGE_W)'(w_old) * (2 * RANGE_W)'(w_old);
            ST_MUL: begin
                r_p1 <= w_p1;
                r_p2 <= w_p2;
                r_nn <= w_nn;
            end
            ST_DIFF: begin
                r_rem  <= r_p1 - r_p2;
                r_dsh  <= NW'({w_den, (Q_BITS - 1)'(0)});
                r_q    <= '0;
                r_step <= '0;
            end
            ST_DIV: begin
                if (w_ge) begin
                    r_rem <= r_rem - r_dsh;
                end
                r_dsh  <= r_dsh >> 1;
                r_q    <= {r_q[Q_BITS-2:0], w_ge};
                r_step <= r_step + 1'b1;
            end
            default: ;
        endcase
    end

    assign empty      = !r_out_valid;
    assign o_out_word = r_out_word;

endmodule

### hw/rtl/swrv_checker.sv
// Port-level checks for the sliding window range variance block.
// Bound to the top level; depends on swrv_pkg.
module swrv_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       push,
    input logic                       full,
    input logic                       empty,
    input logic                       pop,
    input swrv_pkg::t_out_word        o_out_word
);
    import swrv_pkg::*;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!full && empty))
        else $error("queues not cleared by reset");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_word)))
        else $error("waiting result word changed or vanished");

    a_clip_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_word.clipped) |-> (o_out_word.covariance_out == COV_MAX))
        else $error("clipped word not saturated");

    a_full_needs_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(full) |-> $past(push))
        else $error("full rose without a pushed word");

endmodule

bind sliding_window_range_variance swrv_checker u_swrv_checker (.*);
